FILE: rtl/ktp_pkg.sv
// Package for the knob soft-takeover panel unit.
// Holds sizes, field widths, shared types and the wrap helper; no dependencies.
package ktp_pkg;

    localparam int unsigned CHANNELS  = 3;
    localparam int unsigned SHAPES    = 4;
    localparam int unsigned MOD_DESTS = 4;
    localparam int unsigned KNOBS     = 4;

    localparam int unsigned CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned KNOB_W    = 10;
    localparam int unsigned LEN_W     = 9;
    localparam int unsigned WIN_W     = 6;
    localparam int unsigned PANEL_KNOBS = 4;

    localparam logic [KNOB_W-1:0] STORED_RESET = 10'd10;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 6'd5;

    // floor(v * 513 / 1027) == (v * LEN_RECIP) >> LEN_SHIFT for every 10-bit v
    localparam int unsigned       LEN_SHIFT = 30;
    localparam logic [28:0]       LEN_RECIP = 29'd536348169;

    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 56;

    typedef struct packed {
        logic [1:0] channel;
        logic [1:0] shape;
        logic       shape_set;
        logic [1:0] mod_source;
        logic       mod_source_set;
        logic [1:0] mod_dest;
        logic       mod_dest_set;
        logic       relock;
    } t_ctrl;

    function automatic logic [1:0] wrap_next(input logic [1:0] v, input int unsigned count);
        logic [2:0] inc;
        inc = {1'b0, v} + 3'd1;
        return (inc >= 3'(count)) ? 2'd0 : inc[1:0];
    endfunction

endpackage

FILE: rtl/ktp_ctrl.sv
// Button edge detection, cycling selectors and the pickup window register.
// Depends on ktp_pkg.
module ktp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [3:0]                 i_buttons,
    input  logic                       i_window_we,
    input  logic [ktp_pkg::WIN_W-1:0]  i_window,
    output ktp_pkg::t_ctrl             o_ctrl,
    output logic [ktp_pkg::WIN_W-1:0]  o_window
);
    import ktp_pkg::*;

    logic [3:0]       r_held;
    logic [1:0]       r_channel;
    logic [1:0]       r_shape;
    logic [1:0]       r_src;
    logic [1:0]       r_dst;
    logic [WIN_W-1:0] r_window;
    logic [3:0]       edges;
    t_ctrl            n_ctrl;

    assign edges = i_buttons & ~r_held;

    always_comb begin
        n_ctrl.channel        = edges[0] ? wrap_next(r_channel, CHANNELS) : r_channel;
        n_ctrl.relock         = edges[0];
        n_ctrl.shape          = edges[1] ? wrap_next(r_shape, SHAPES) : r_shape;
        n_ctrl.shape_set      = edges[1];
        n_ctrl.mod_source     = edges[2] ? wrap_next(r_src, CHANNELS) : r_src;
        n_ctrl.mod_source_set = edges[2];
        n_ctrl.mod_dest       = edges[3] ? wrap_next(r_dst, MOD_DESTS) : r_dst;
        n_ctrl.mod_dest_set   = edges[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_channel <= '0;
            r_shape   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_window  <= WINDOW_RESET;
        end else begin
            if (i_accept) begin
                r_held    <= i_buttons;
                r_channel <= n_ctrl.channel;
                r_shape   <= n_ctrl.shape;
                r_src     <= n_ctrl.mod_source;
                r_dst     <= n_ctrl.mod_dest;
            end
            if (i_window_we) begin
                r_window <= i_window;
            end
        end
    end

    assign o_ctrl   = n_ctrl;
    assign o_window = r_window;

endmodule

FILE: rtl/ktp_lane.sv
// One knob lane: lock flag, per-channel stored value and the pickup compare.
// Depends on ktp_pkg.
module ktp_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_relock,
    input  logic [1:0]                  i_channel,
    input  logic [ktp_pkg::WIN_W-1:0]   i_window,
    input  logic [ktp_pkg::KNOB_W-1:0]  i_reading,
    output logic                        o_enable,
    output logic [ktp_pkg::KNOB_W-1:0]  o_value
);
    import ktp_pkg::*;

    logic                r_locked;
    logic [KNOB_W-1:0]   r_store [CHANNELS];
    logic [CH_IDX_W-1:0] slot;
    logic [KNOB_W-1:0]   stored;
    logic [KNOB_W-1:0]   diff;
    logic                locked_in;
    logic                n_locked;

    assign slot      = i_channel[CH_IDX_W-1:0];
    assign stored    = r_store[slot];
    assign diff      = (i_reading >= stored) ? i_reading - stored : stored - i_reading;
    assign locked_in = r_locked | i_relock;
    assign n_locked  = locked_in & (diff > {{(KNOB_W-WIN_W){1'b0}}, i_window});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                r_store[c] <= STORED_RESET;
            end
        end else if (i_accept) begin
            r_locked <= n_locked;
            if (!n_locked) begin
                r_store[slot] <= i_reading;
            end
        end
    end

    assign o_enable = ~n_locked;
    assign o_value  = n_locked ? '0 : i_reading;

endmodule

FILE: rtl/ktp_merge.sv
// Merges lane results with selector state, scales length, and holds the
// output register plus skid entry. Depends on ktp_pkg.
module ktp_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  ktp_pkg::t_ctrl                         i_ctrl,
    input  logic [ktp_pkg::PANEL_KNOBS-1:0]        i_enables,
    input  logic [ktp_pkg::PANEL_KNOBS-1:0][ktp_pkg::KNOB_W-1:0] i_values,
    input  logic                                   i_out_ready,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    output logic [ktp_pkg::M_DATA_W-1:0]           o_out_data
);
    import ktp_pkg::*;

    logic [38:0]         len_prod;
    logic [LEN_W-1:0]    len_q;
    logic [M_DATA_W-1:0] packed_res;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_skid_data;
    logic                r_skid_valid;
    logic                pop;

    assign len_prod = {29'd0, i_values[1]} * {10'd0, LEN_RECIP};
    assign len_q    = len_prod[LEN_SHIFT +: LEN_W];

    assign packed_res = {2'b00, i_values[3], i_values[2], len_q, i_values[0], i_enables,
                         i_ctrl.mod_dest_set, i_ctrl.mod_dest,
                         i_ctrl.mod_source_set, i_ctrl.mod_source,
                         i_ctrl.shape_set, i_ctrl.shape, i_ctrl.channel};

    assign pop = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                    r_out_data  <= packed_res;
                end
            end else if (i_push) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= packed_res;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= packed_res;
                end
            end
        end
    end

    assign o_in_ready  = ~r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/knob_soft_takeover_panel_unit.sv
// Each scan's result is registered in the output register, or the skid entry when full.
// Throughput: one scan per cycle; the output register and one skid entry let a scan
// enter while a result still waits, so s_axis_tready falls only when both are full.
// Reset (i_rst_n low, synchronous): window 5, selectors zero, all knobs locked,
// stored values 10, no result pending.
// Depends on ktp_pkg, ktp_ctrl, ktp_lane and ktp_merge.
module knob_soft_takeover_panel_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [0] button_channel, [1] button_shape, [2] button_mod_source, [3] button_mod_dest,
    // [13:4] knob_speed, [23:14] knob_length, [33:24] knob_weight, [43:34] knob_amount
    input  logic [ktp_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] channel, [3:2] shape, [4] shape_set, [6:5] mod_source, [7] mod_source_set,
    // [9:8] mod_dest, [10] mod_dest_set, [14:11] knob_enables, [24:15] speed,
    // [33:25] length, [43:34] weight, [53:44] mod_amount
    output logic [ktp_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input  logic                           i_pickup_window_we,
    input  logic [ktp_pkg::WIN_W-1:0]      i_pickup_window
);
    import ktp_pkg::*;

    logic                                     accept;
    t_ctrl                                    ctrl;
    logic [WIN_W-1:0]                         window;
    logic [PANEL_KNOBS-1:0]                   enables;
    logic [PANEL_KNOBS-1:0][KNOB_W-1:0]       values;

    assign accept = s_axis_tvalid & s_axis_tready;

    ktp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_buttons   (s_axis_tdata[3:0]),
        .i_window_we (i_pickup_window_we),
        .i_window    (i_pickup_window),
        .o_ctrl      (ctrl),
        .o_window    (window)
    );

    for (genvar k = 0; k < PANEL_KNOBS; k++) begin : g_lane
        if (k < KNOBS) begin : g_on
            ktp_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_accept  (accept),
                .i_relock  (ctrl.relock),
                .i_channel (ctrl.channel),
                .i_window  (window),
                .i_reading (s_axis_tdata[4 + k*KNOB_W +: KNOB_W]),
                .o_enable  (enables[k]),
                .o_value   (values[k])
            );
        end else begin : g_off
            assign enables[k] = 1'b0;
            assign values[k]  = '0;
        end
    end

    ktp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_ctrl      (ctrl),
        .i_enables   (enables),
        .i_values    (values),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
